/* design/cba_pkg.sv */
// Shared types and constants for the commanded block averager.
// No dependencies.
`default_nettype none
package cba_pkg;
    localparam logic [2:0] KIND_TICK = 3'd0;
    localparam logic [2:0] KIND_KEY = 3'd1;
    localparam logic [2:0] KIND_CMD = 3'd2;
    localparam logic [2:0] KIND_RATE_OK = 3'd3;
    localparam logic [2:0] KIND_RATE_BAD = 3'd4;
    localparam logic [11:0] AGE_MAX = 12'd4095;
    localparam logic [10:0] VAL_SAT = 11'd1001;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_BLINK = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic do_item;     // apply one input item (state update, results latched)
        logic div_start;   // load divider
        logic div_step;    // one restoring step
        logic commit_tick; // write averaging results after mean division
        logic commit_rate; // write block length after rate division
    } cba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_mean;
        logic need_rate;
        logic div_done;
        logic [1:0] nres;
    } cba_stat_t;

    typedef struct packed {
        logic [2:0] kind;
        logic av;
        logic [11:0] avg;
        logic last;
    } cba_res_t;
endpackage
`default_nettype wire

/* design/commanded_block_averager_unit.sv */
// Top level of the commanded block averager: APB registers, sequencer and
// datapath. Depends on cba_pkg, cba_ctrl, cba_datapath.
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | tdata: operation, sample, sample_ok, key_low, rx_byte
// m_      | out | m_tvalid/m_tready  | tdata, tuser = report_kind, tlast
// apb     | in  | psel/penable       | debounce_ticks @0, blink_ticks @4
//
// One item at a time. A tick that closes a block, or a valid rate command,
// takes the intake cycle plus the shared restoring divider: 22 steps and a
// commit cycle, then its results in order. Other items take the intake
// cycle plus their results, and the sequencer returns to idle after the
// last result before it takes the next request. Synchronous active-low
// reset; a stalled m_ holds s_.
`default_nettype none
module commanded_block_averager_unit #(
    parameter int LINE_BYTES = 10,
    parameter int BASE_RATE = 1000
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    output logic s_tready,
    // [0] operation [12:1] sample [13] sample_ok [14] key_low [22:15] rx_byte, pad
    input wire logic [23:0] s_tdata,
    output logic m_tvalid,
    input wire logic m_tready,
    // [0] average_valid [12:1] average [13] running [23:14] rate_hz
    // [33:24] samples_per_avg [34] compact [35] led_on, pad
    output logic [39:0] m_tdata,
    // [2:0] report_kind
    output logic [2:0] m_tuser,
    output logic m_tlast,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [2:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import cba_pkg::*;

    logic [11:0] deb_reg, blink_reg;
    cba_cmd_t cmd;
    cba_stat_t stat;
    cba_res_t res;
    logic out_sel, run, led;
    logic [9:0] rate, blen;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg <= 12'd200;
            blink_reg <= 12'd200;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_DEBOUNCE[0]: deb_reg <= pwdata[11:0];
                default: blink_reg <= pwdata[11:0];
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BLINK[0]) prdata[11:0] = blink_reg;
        else prdata[11:0] = deb_reg;
    end

    cba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_ready(m_tready), .out_valid(m_tvalid), .out_sel(out_sel),
        .stat(stat), .cmd(cmd)
    );

    cba_datapath #(.LINE_BYTES(LINE_BYTES), .BASE_RATE(BASE_RATE)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .debounce_ticks(deb_reg), .blink_ticks(blink_reg),
        .in_op(s_tdata[0]), .in_sample(s_tdata[12:1]), .in_ok(s_tdata[13]),
        .in_key(s_tdata[14]), .in_byte(s_tdata[22:15]),
        .out_sel(out_sel), .res(res),
        .run_o(run), .rate_o(rate), .blen_o(blen), .led_o(led)
    );

    assign m_tdata = {4'd0, led, (rate > 10'd500), blen, rate, run, res.avg, res.av};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule
`default_nettype wire

/* design/cba_ctrl.sv */
// Sequencer for the commanded block averager: item intake, divider steps,
// result delivery. Uses cba_pkg.
`default_nettype none
module cba_ctrl (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic out_ready,
    output logic out_valid,
    output logic out_sel,
    input wire cba_pkg::cba_stat_t stat,
    output cba_pkg::cba_cmd_t cmd
);
    import cba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIVM = 5'b00010,
        S_DIVR = 5'b00100,
        S_OUT0 = 5'b01000,
        S_OUT1 = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] nres_reg, nres_next;

    always_comb begin
        state_next = state_reg;
        nres_next = nres_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        out_sel = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.do_item = 1'b1;
                    nres_next = stat.nres;
                    if (stat.need_mean) begin
                        cmd.div_start = 1'b1;
                        state_next = S_DIVM;
                    end else if (stat.need_rate) begin
                        cmd.div_start = 1'b1;
                        state_next = S_DIVR;
                    end else if (stat.nres != 2'd0) begin
                        state_next = S_OUT0;
                    end
                end
            end
            S_DIVM: begin
                if (stat.div_done) begin
                    cmd.commit_tick = 1'b1;
                    state_next = S_OUT0;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DIVR: begin
                if (stat.div_done) begin
                    cmd.commit_rate = 1'b1;
                    state_next = S_OUT0;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT0: begin
                out_valid = 1'b1;
                if (out_ready) state_next = (nres_reg == 2'd2) ? S_OUT1 : S_IDLE;
            end
            S_OUT1: begin
                out_valid = 1'b1;
                out_sel = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            nres_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            nres_reg <= nres_next;
        end
    end
endmodule
`default_nettype wire

/* design/cba_datapath.sv */
// Datapath of the commanded block averager: state registers, line parser,
// shared restoring divider and result registers. Uses cba_pkg.
`default_nettype none
module cba_datapath #(
    parameter int LINE_BYTES = 10,
    parameter int BASE_RATE = 1000
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire cba_pkg::cba_cmd_t cmd,
    output cba_pkg::cba_stat_t stat,
    input wire logic [11:0] debounce_ticks,
    input wire logic [11:0] blink_ticks,
    input wire logic in_op,
    input wire logic [11:0] in_sample,
    input wire logic in_ok,
    input wire logic in_key,
    input wire logic [7:0] in_byte,
    input wire logic out_sel,
    output cba_pkg::cba_res_t res,
    output logic run_o,
    output logic [9:0] rate_o,
    output logic [9:0] blen_o,
    output logic led_o
);
    import cba_pkg::*;

    localparam int LW = $clog2(LINE_BYTES);
    localparam logic [LW-1:0] LINE_MAX = LW'(LINE_BYTES - 1);
    localparam int BW = $clog2(BASE_RATE + 1);
    localparam int DW = (BW > 22) ? BW : 22;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] BASE = DW'(BASE_RATE);

    logic run_reg, led_reg, neg_reg;
    logic [9:0] rate_reg, blen_reg, cnt_reg;
    logic [21:0] sum_reg;
    logic [11:0] kage_reg, bage_reg;
    logic [LW-1:0] len_reg;
    logic [7:0] first_reg;
    logic [1:0] phase_reg;
    logic [10:0] val_reg;
    cba_res_t r0_reg, r1_reg;
    // pending tick state awaiting the mean
    logic pend_rate_reg;

    logic [DW-1:0] q_reg, rem_reg, den_reg;
    logic [CW-1:0] step_reg;

    // tick preview
    logic [11:0] kage_inc, bage_inc;
    logic key_hit, run_t;
    logic [21:0] sum_t;
    logic [9:0] cnt_t;
    logic mean_due;
    logic is_end, is_digit, rate_good;

    always_comb begin
        kage_inc = (kage_reg >= AGE_MAX) ? AGE_MAX : kage_reg + 12'd1;
        bage_inc = (bage_reg >= AGE_MAX) ? AGE_MAX : bage_reg + 12'd1;
        key_hit = in_key && (kage_inc > debounce_ticks);
        run_t = run_reg ^ key_hit;
        sum_t = sum_reg + ((run_t && in_ok) ? {10'd0, in_sample} : 22'd0);
        cnt_t = cnt_reg + ((run_t && in_ok) ? 10'd1 : 10'd0);
        mean_due = run_t && (cnt_t >= blen_reg) && (cnt_t != 10'd0);
        is_end = (in_byte == CH_LF) || (in_byte == CH_CR) || (len_reg >= LINE_MAX);
        is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
        rate_good = !neg_reg && (val_reg >= 11'd1) && (val_reg <= 11'd1000);
        stat.need_mean = !in_op && mean_due;
        stat.need_rate = in_op && is_end && (len_reg != '0) && (first_reg == CH_T)
                         && rate_good;
        stat.div_done = (step_reg == '0);
        if (!in_op) stat.nres = key_hit ? 2'd2 : 2'd1;
        else if (is_end && (len_reg != '0) && (first_reg == CH_C || first_reg == CH_T))
            stat.nres = 2'd1;
        else stat.nres = 2'd0;
    end

    logic [DW:0] trial;
    assign trial = {rem_reg, q_reg[DW-1]} - {1'b0, den_reg};

    logic [13:0] val_mul;
    assign val_mul = (14'(val_reg) * 14'd10) + {10'd0, in_byte[3:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b1;
            rate_reg <= 10'd4;
            blen_reg <= 10'd250;
            sum_reg <= '0;
            cnt_reg <= '0;
            kage_reg <= '0;
            bage_reg <= '0;
            led_reg <= 1'b0;
            len_reg <= '0;
            first_reg <= '0;
            phase_reg <= PH_SKIP;
            val_reg <= '0;
            neg_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (cmd.do_item && !in_op) begin
                kage_reg <= key_hit ? 12'd0 : kage_inc;
                run_reg <= run_t;
                r1_reg <= '{kind: KIND_TICK, av: 1'b0, avg: 12'd0, last: 1'b1};
                if (key_hit) r0_reg <= '{kind: KIND_KEY, av: 1'b0, avg: 12'd0, last: 1'b0};
                else r0_reg <= '{kind: KIND_TICK, av: 1'b0, avg: 12'd0, last: 1'b1};
                if (run_t) begin
                    sum_reg <= mean_due ? 22'd0 : sum_t;
                    cnt_reg <= mean_due ? 10'd0 : cnt_t;
                    if (bage_inc > blink_ticks) begin
                        led_reg <= !led_reg;
                        bage_reg <= '0;
                    end else begin
                        bage_reg <= bage_inc;
                    end
                end else begin
                    bage_reg <= bage_inc;
                    led_reg <= 1'b0;
                end
                if (mean_due) begin
                    q_reg <= DW'(sum_t);
                    den_reg <= DW'(cnt_t);
                end
                if (mean_due) begin
                    pend_rate_reg <= key_hit;
                end
            end
            if (cmd.do_item && in_op) begin
                if (is_end) begin
                    len_reg <= '0;
                    if (len_reg != '0 && first_reg == CH_C) begin
                        run_reg <= !run_reg;
                        if (run_reg) led_reg <= 1'b0;
                        r0_reg <= '{kind: KIND_CMD, av: 1'b0, avg: 12'd0, last: 1'b1};
                    end else begin
                        if (!run_reg) led_reg <= 1'b0;
                        r0_reg <= '{kind: stat.need_rate ? KIND_RATE_OK : KIND_RATE_BAD,
                                    av: 1'b0, avg: 12'd0, last: 1'b1};
                    end
                    if (stat.need_rate) begin
                        rate_reg <= val_reg[9:0];
                        sum_reg <= '0;
                        cnt_reg <= '0;
                        q_reg <= BASE;
                        den_reg <= DW'(val_reg);
                    end
                end else begin
                    len_reg <= len_reg + LW'(1);
                    if (!run_reg) led_reg <= 1'b0;
                    if (len_reg == '0) begin
                        first_reg <= in_byte;
                        phase_reg <= PH_SKIP;
                        val_reg <= '0;
                        neg_reg <= 1'b0;
                    end else begin
                        case (phase_reg)
                            PH_SKIP: begin
                                if (in_byte == CH_SP || in_byte == CH_TAB ||
                                    in_byte == CH_VT || in_byte == CH_FF) begin
                                    phase_reg <= PH_SKIP;
                                end else if (in_byte == CH_PLUS) begin
                                    phase_reg <= PH_DIGITS;
                                end else if (in_byte == CH_MINUS) begin
                                    phase_reg <= PH_DIGITS;
                                    neg_reg <= 1'b1;
                                end else if (!is_digit) begin
                                    phase_reg <= PH_DONE;
                                end else begin
                                    phase_reg <= PH_DIGITS;
                                    val_reg <= (val_mul > 14'(VAL_SAT)) ? VAL_SAT
                                                                        : val_mul[10:0];
                                end
                            end
                            PH_DIGITS: begin
                                if (!is_digit) phase_reg <= PH_DONE;
                                else val_reg <= (val_mul > 14'(VAL_SAT)) ? VAL_SAT
                                                                         : val_mul[10:0];
                            end
                            default: ;
                        endcase
                    end
                end
            end
            if (cmd.div_start) begin
                rem_reg <= '0;
                step_reg <= CW'(DW);
            end
            if (cmd.div_step) begin
                step_reg <= step_reg - CW'(1);
                if (!trial[DW]) begin
                    rem_reg <= trial[DW-1:0];
                    q_reg <= {q_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[DW-2:0], q_reg[DW-1]};
                    q_reg <= {q_reg[DW-2:0], 1'b0};
                end
            end
            if (cmd.commit_tick) begin
                if (pend_rate_reg) begin
                    r1_reg.av <= 1'b1;
                    r1_reg.avg <= q_reg[11:0];
                end else begin
                    r0_reg.av <= 1'b1;
                    r0_reg.avg <= q_reg[11:0];
                end
            end
            if (cmd.commit_rate) begin
                if (q_reg == '0) blen_reg <= 10'd1;
                else if (q_reg > DW'(1023)) blen_reg <= 10'd1023;
                else blen_reg <= q_reg[9:0];
            end
        end
    end

    assign res = out_sel ? r1_reg : r0_reg;
    assign run_o = run_reg;
    assign rate_o = rate_reg;
    assign blen_o = blen_reg;
    assign led_o = led_reg;
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for commanded_block_averager_unit.
// Needs cba_pkg and the design sources; the behavior is predicted here and
// every result is compared in order, field by field, under random idling.
`timescale 1ns / 100ps
module tb;
    import cba_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 250;

    typedef struct {
        logic [2:0]  kind;
        logic        av;
        logic [11:0] avg;
        logic        run;
        logic [9:0]  rate;
        logic [9:0]  spa;
        logic        compact;
        logic        led;
        logic        last;
    } report_t;

    typedef struct {
        logic        op;
        logic [11:0] sample;
        logic        ok;
        logic        key;
        logic [7:0]  rx;
        bit          typed;
        report_t     want;
    } stim_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    commanded_block_averager_unit dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predicted state
    logic [11:0] cfg_debounce, cfg_blink;
    logic        run_st, led_st;
    logic [9:0]  rate_st, blen_st, count_st;
    logic [21:0] sum_st;
    logic [11:0] key_age_st, blink_age_st;
    logic [3:0]  line_len_st;
    logic [7:0]  first_st;
    logic [1:0]  phase_st;
    logic [10:0] value_st;
    logic        neg_st;

    report_t expected_reports[$];
    int      errors = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      quiet_cycles = 0;

    function automatic report_t make_report(logic [2:0] kind, logic av, logic [11:0] avg,
                                            logic last);
        report_t r;
        r.kind = kind;
        r.av = av;
        r.avg = avg;
        r.run = run_st;
        r.rate = rate_st;
        r.spa = blen_st;
        r.compact = rate_st > 10'd500;
        r.led = led_st;
        r.last = last;
        return r;
    endfunction

    function automatic void parse_digit_byte(logic [7:0] b);
        bit          digit;
        int unsigned v;
        digit = b >= CH_0 && b <= CH_9;
        if (phase_st == PH_SKIP) begin
            if (b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF) return;
            if (b == CH_PLUS) begin
                phase_st = PH_DIGITS;
                return;
            end
            if (b == CH_MINUS) begin
                neg_st = 1;
                phase_st = PH_DIGITS;
                return;
            end
            if (!digit) begin
                phase_st = PH_DONE;
                return;
            end
            phase_st = PH_DIGITS;
        end else if (phase_st == PH_DIGITS) begin
            if (!digit) begin
                phase_st = PH_DONE;
                return;
            end
        end else begin
            return;
        end
        v = value_st * 10 + (b - CH_0);
        value_st = v > VAL_SAT ? VAL_SAT : v[10:0];
    endfunction

    // advance the predicted state by one request and queue its reports
    function automatic void predict_reports(stim_row_t it, output report_t r[$]);
        bit          key_hit, av, emit;
        logic [11:0] avg;
        logic [2:0]  kind;
        int unsigned n;
        r = {};
        if (!it.op) begin
            key_hit = 0;
            av = 0;
            avg = '0;
            if (key_age_st != AGE_MAX) key_age_st++;
            if (blink_age_st != AGE_MAX) blink_age_st++;
            if (it.key && key_age_st > cfg_debounce) begin
                run_st = ~run_st;
                key_age_st = '0;
                key_hit = 1;
            end
            if (run_st) begin
                if (it.ok) begin
                    sum_st += it.sample;
                    count_st++;
                end
                if (count_st >= blen_st && count_st != 0) begin
                    avg = 12'(sum_st / count_st);
                    av = 1;
                    sum_st = '0;
                    count_st = '0;
                end
                if (blink_age_st > cfg_blink) begin
                    led_st = ~led_st;
                    blink_age_st = '0;
                end
            end else begin
                led_st = 0;
            end
            if (key_hit) r.push_back(make_report(KIND_KEY, 0, '0, 0));
            r.push_back(make_report(KIND_TICK, av, avg, 1));
            return;
        end
        if (it.rx == CH_LF || it.rx == CH_CR || line_len_st >= 9) begin
            emit = 0;
            kind = KIND_TICK;
            if (line_len_st > 0) begin
                if (first_st == CH_C) begin
                    run_st = ~run_st;
                    kind = KIND_CMD;
                    emit = 1;
                end else if (first_st == CH_T) begin
                    emit = 1;
                    if (!neg_st && value_st >= 1 && value_st <= 1000) begin
                        n = 1000 / value_st;
                        rate_st = value_st[9:0];
                        blen_st = n == 0 ? 10'd1 : n[9:0];
                        sum_st = '0;
                        count_st = '0;
                        kind = KIND_RATE_OK;
                    end else begin
                        kind = KIND_RATE_BAD;
                    end
                end
            end
            line_len_st = 0;
            if (!run_st) led_st = 0;
            if (emit) r.push_back(make_report(kind, 0, '0, 1));
            return;
        end
        if (line_len_st == 0) begin
            first_st = it.rx;
            phase_st = PH_SKIP;
            value_st = '0;
            neg_st = 0;
        end else begin
            parse_digit_byte(it.rx);
        end
        line_len_st++;
        if (!run_st) led_st = 0;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    task automatic send_request(stim_row_t it);
        report_t r[$];
        while ($urandom_range(99) < send_gap) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {1'b0, it.rx, it.key, it.ok, it.sample, it.op};
        do @(posedge aclk); while (!s_tready);
        predict_reports(it, r);
        if (it.typed) r[0] = it.want;
        foreach (r[i]) expected_reports.push_back(r[i]);
    endtask

    task automatic send_byte(logic [7:0] b);
        stim_row_t it;
        it = '{op: 1, sample: 12'($urandom), ok: 1'($urandom), key: 1'($urandom), rx: b,
               typed: 0, want: '{default: '0}};
        send_request(it);
    endtask

    task automatic send_tick(logic [11:0] s, logic ok, logic key);
        stim_row_t it;
        it = '{op: 0, sample: s, ok: ok, key: key, rx: 8'($urandom), typed: 0,
               want: '{default: '0}};
        send_request(it);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [11:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 3'(idx) << 2;
        pwdata <= {20'h0, value};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        if (idx == REG_DEBOUNCE) cfg_debounce = value;
        else cfg_blink = value;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge aclk);
    endtask

    // result side: random backpressure, in-order comparison, watchdog
    always @(posedge aclk) begin
        report_t w;
        m_tready <= $urandom_range(99) >= recv_gap;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** commanded_block_averager_unit: FAILED **");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected report kind", m_tuser, -1);
            end else begin
                w = expected_reports.pop_front();
                if (m_tuser !== w.kind) report_mismatch("report_kind", m_tuser, w.kind);
                if (m_tdata[0] !== w.av) report_mismatch("average_valid", m_tdata[0], w.av);
                if (m_tdata[12:1] !== w.avg) report_mismatch("average", m_tdata[12:1], w.avg);
                if (m_tdata[13] !== w.run) report_mismatch("running", m_tdata[13], w.run);
                if (m_tdata[23:14] !== w.rate) report_mismatch("rate_hz", m_tdata[23:14], w.rate);
                if (m_tdata[33:24] !== w.spa)
                    report_mismatch("samples_per_avg", m_tdata[33:24], w.spa);
                if (m_tdata[34] !== w.compact) report_mismatch("compact", m_tdata[34], w.compact);
                if (m_tdata[35] !== w.led) report_mismatch("led_on", m_tdata[35], w.led);
                if (m_tlast !== w.last) report_mismatch("tlast", m_tlast, w.last);
            end
        end
    end

    // one random command line or tick burst
    task automatic random_episode(ref int sent);
        int    pick;
        int    num;
        string txt;
        pick = $urandom_range(99);
        if (pick < 45) begin
            repeat ($urandom_range(12, 1)) begin
                send_tick(12'($urandom), ($urandom % 8) != 0, ($urandom % 12) == 0);
                sent++;
            end
        end else if (pick < 72) begin
            txt = "t";
            repeat ($urandom_range(2)) begin
                case ($urandom_range(3))
                    0: txt = {txt, " "};
                    1: txt = {txt, "\t"};
                    2: txt = {txt, string'(CH_VT)};
                    default: txt = {txt, string'(CH_FF)};
                endcase
            end
            case ($urandom_range(9))
                0: txt = {txt, "-"};
                1, 2: txt = {txt, "+"};
                default: ;
            endcase
            if ($urandom_range(99) < 85) num = $urandom_range(2) ? $urandom_range(1000, 150)
                                                                 : $urandom_range(1000, 1);
            else num = $urandom_range(99999);
            txt = {txt, $sformatf("%0d", num)};
            if ($urandom_range(4) == 0) txt = {txt, "x"};
            txt = {txt, $urandom_range(1) ? "\n" : "\r"};
            send_text(txt);
            sent += txt.len();
        end else if (pick < 82) begin
            send_text($urandom_range(1) ? "c\n" : "c\r");
            sent += 2;
        end else if (pick < 90) begin
            num = $urandom_range(12, 9);
            send_byte($urandom_range(1) ? CH_T : 8'($urandom));
            repeat (num) send_byte(8'($urandom));
            sent += num + 1;
        end else begin
            send_byte(8'($urandom));
            sent++;
        end
    endtask

    stim_row_t directed_rows[$];
    string     directed_text[$];

    initial begin
        int sent;
        cfg_debounce = 12'd200;
        cfg_blink = 12'd200;
        run_st = 1;
        rate_st = 10'd4;
        blen_st = 10'd250;
        sum_st = '0;
        count_st = '0;
        key_age_st = '0;
        blink_age_st = '0;
        led_st = 0;
        line_len_st = '0;
        first_st = '0;
        phase_st = PH_SKIP;
        value_st = '0;
        neg_st = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        apb_write(REG_DEBOUNCE, 12'd0);
        apb_write(REG_BLINK, 12'd0);
        send_gap = 12;
        recv_gap = 53;

        // first tick after reset: blink interval of zero lights the LED
        directed_rows.push_back('{op: 0, sample: 12'd100, ok: 1, key: 0, rx: 8'h00, typed: 1,
            want: '{kind: KIND_TICK, av: 0, avg: '0, run: 1, rate: 10'd4, spa: 10'd250,
                    compact: 0, led: 1, last: 1}});
        directed_rows.push_back('{op: 0, sample: 12'hFFF, ok: 1, key: 1, rx: 8'hFF, typed: 0,
            want: '{default: '0}});
        foreach (directed_rows[i]) send_request(directed_rows[i]);
        directed_text = '{"c\n", "t1000\n"};
        foreach (directed_text[i]) send_text(directed_text[i]);
        send_tick(12'hFFF, 1, 0);
        send_tick(12'h000, 1, 0);
        send_tick(12'hABC, 0, 1);
        directed_text = '{"t-5\n", "\n", "x\n", "t0\r"};
        foreach (directed_text[i]) send_text(directed_text[i]);

        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    apb_write(REG_DEBOUNCE, 12'd4095);
                    apb_write(REG_BLINK, 12'd4095);
                end
                1: begin
                    apb_write(REG_DEBOUNCE, 12'd3);
                    apb_write(REG_BLINK, 12'd5);
                    send_gap = 53;
                    recv_gap = 12;
                end
                default: begin
                    apb_write(REG_DEBOUNCE, 12'($urandom_range(20)));
                    apb_write(REG_BLINK, 12'($urandom_range(20)));
                    send_gap = 0;
                    recv_gap = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) random_episode(sent);
        end

        wait_idle();
        if (errors == 0) begin
            $display("** commanded_block_averager_unit: PASSED **");
        end else begin
            $display("** commanded_block_averager_unit: FAILED **");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/cba_pkg.sv
design/cba_ctrl.sv
design/cba_datapath.sv
design/commanded_block_averager_unit.sv
tb/tb.sv
